// ===== src/tsvd_pkg.sv =====
// Shared types, codes and arithmetic helpers for the three-state Viterbi decoder.
`default_nettype none
package tsvd_pkg;

  localparam int CostW  = 16;
  localparam int ScoreW = 32;
  localparam int GainW  = 16;
  localparam int GainFrac = 12;
  localparam int IndexW = 12;
  localparam int LenW   = 13;
  localparam int SumW   = ScoreW + 1;
  localparam int ProdW  = SumW + GainW;

  localparam int InDataW  = 64;
  localparam int OutDataW = 56;

  typedef logic [1:0]        action_t;
  typedef logic [1:0]        label_t;
  typedef logic [ScoreW-1:0] score_t;
  typedef logic [CostW-1:0]  cost_t;
  typedef logic [3:0]        bptr_t;

  localparam action_t ACT_PUSH   = 2'd0;
  localparam action_t ACT_FINISH = 2'd1;
  localparam action_t ACT_READ   = 2'd2;
  localparam action_t ACT_NOP    = 2'd3;

  localparam label_t LAB_E = 2'd0;
  localparam label_t LAB_I = 2'd1;
  localparam label_t LAB_X = 2'd2;

  function automatic score_t plain_sum(input score_t s, input cost_t c);
    logic [SumW-1:0] sum;
    sum = {1'b0, s} + SumW'(c);
    return sum[SumW-1] ? '1 : sum[ScoreW-1:0];
  endfunction

  function automatic score_t gain_round(input logic [ProdW-1:0] prod);
    logic [ProdW:0]            rnd;
    logic [ProdW-GainFrac:0]   shr;
    rnd = {1'b0, prod} + (ProdW+1)'(1 << (GainFrac - 1));
    shr = rnd[ProdW:GainFrac];
    return (|shr[ProdW-GainFrac:ScoreW]) ? '1 : shr[ScoreW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/three_state_viterbi_decoder_top.sv =====
// Top level of the three-state Viterbi decoder: sequencer, shared gain multiplier and stores.
`default_nettype none
// Items are taken one at a time. A push steps through the multiply states and then the
// add-compare-select state: one 33x16 multiplier is shared by the three self-transition gain
// terms in turn, a final multiply step rounds the last product, and the add-compare-select step
// updates the path scores and writes the back-pointer word. A push dropped at capacity stays in
// the idle state and sets the overflow flag. A finish walks the trace-back, reading the
// single-port back-pointer memory and writing the path store, in separate states per position.
// A read registers the path-store access at acceptance. A result waits in an output register,
// so a push may be accepted while an earlier result has not been taken yet; a finish or a read
// holds in its last cycle until that register is free.
module three_state_viterbi_decoder_top #(
  parameter int MAX_LEN = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [tsvd_pkg::GainW-1:0]    cfg_wr_data,   // self_gain
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // cost_e[15:0], cost_i[31:16], cost_x[47:32], index[59:48], zero fill
  input  wire logic [tsvd_pkg::InDataW-1:0]  in_tdata,
  input  wire logic [1:0]                    in_tuser,      // action[1:0]
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // label[1:0], final_score[33:2], path_length[46:34], overflow[47], bad_index[48], zero fill
  output logic [tsvd_pkg::OutDataW-1:0]      out_tdata
);

  localparam int AW  = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
  localparam int CW  = $clog2(MAX_LEN + 1);
  localparam int XW  = (AW > tsvd_pkg::IndexW) ? AW : tsvd_pkg::IndexW;
  localparam int BW  = (CW > tsvd_pkg::IndexW) ? CW : tsvd_pkg::IndexW;
  localparam int PW  = (CW > tsvd_pkg::LenW) ? CW : tsvd_pkg::LenW;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MUL      = 3'd1;
  localparam logic [2:0] ST_ACS      = 3'd2;
  localparam logic [2:0] ST_TRACE_RD = 3'd3;
  localparam logic [2:0] ST_TRACE_WR = 3'd4;
  localparam logic [2:0] ST_EMIT     = 3'd5;

  logic [2:0]                    state_r;
  logic [1:0]                    step_r;
  logic [tsvd_pkg::GainW-1:0]    gain_r;
  tsvd_pkg::score_t              se_r, si_r, sx_r;
  tsvd_pkg::score_t              g_r [3];
  logic [tsvd_pkg::ProdW-1:0]    prod_r;
  tsvd_pkg::cost_t               ce_r, ci_r, cx_r;
  logic [CW-1:0]                 count_r;
  logic [CW-1:0]                 p_r;
  logic                          new_seq_r;
  logic                          ovf_r;
  tsvd_pkg::label_t              lab_r;
  tsvd_pkg::score_t              best_r;
  logic                          is_read_r;
  logic                          bad_r;
  logic                          out_valid_r;
  logic [tsvd_pkg::OutDataW-1:0] out_data_r;

  logic [3:0]                    bp_mem [MAX_LEN];
  tsvd_pkg::label_t              ps_mem [MAX_LEN];
  tsvd_pkg::bptr_t               bp_rdata_r;
  tsvd_pkg::label_t              ps_rdata_r;

  logic                          in_fire;
  tsvd_pkg::action_t             in_action;
  tsvd_pkg::cost_t               in_ce, in_ci, in_cx;
  logic [tsvd_pkg::IndexW-1:0]   in_index;
  logic [XW-1:0]                 idx_x;
  logic [BW-1:0]                 idx_b, cnt_b;
  logic                          rd_bad;
  logic [CW-1:0]                 p_dec;
  logic [PW-1:0]                 cnt_p;

  tsvd_pkg::score_t              mul_s;
  tsvd_pkg::cost_t               mul_c;
  logic [tsvd_pkg::SumW-1:0]     mul_sum;

  tsvd_pkg::score_t              e_from_i, e_from_x, i_from_e, i_from_i, x_from_e, x_from_x;
  tsvd_pkg::score_t              ne_nxt, ni_nxt, nx_nxt;
  tsvd_pkg::bptr_t               bp_nxt;
  tsvd_pkg::label_t              lab_nxt;
  tsvd_pkg::label_t              out_label;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_action  = in_tuser;
  assign in_ce      = in_tdata[15:0];
  assign in_ci      = in_tdata[31:16];
  assign in_cx      = in_tdata[47:32];
  assign in_index   = in_tdata[59:48];
  assign idx_x      = XW'(in_index);
  assign idx_b      = BW'(in_index);
  assign cnt_b      = BW'(count_r);
  assign rd_bad     = (idx_b >= cnt_b);
  assign p_dec      = p_r - CW'(1);
  assign cnt_p      = PW'(count_r);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    unique case (step_r)
      2'd0:    begin mul_s = se_r; mul_c = ce_r; end
      2'd1:    begin mul_s = si_r; mul_c = ci_r; end
      default: begin mul_s = sx_r; mul_c = cx_r; end
    endcase
    mul_sum = {1'b0, mul_s} + tsvd_pkg::SumW'(mul_c);
  end

  always_comb begin
    e_from_i = tsvd_pkg::plain_sum(si_r, ce_r);
    e_from_x = tsvd_pkg::plain_sum(sx_r, ce_r);
    i_from_e = tsvd_pkg::plain_sum(se_r, ci_r);
    i_from_i = tsvd_pkg::plain_sum(si_r, ci_r);
    x_from_e = tsvd_pkg::plain_sum(se_r, cx_r);
    x_from_x = tsvd_pkg::plain_sum(sx_r, cx_r);
    bp_nxt   = '0;
    if (e_from_i < g_r[0]) begin
      if (e_from_i < e_from_x) begin
        ne_nxt = e_from_i;
        bp_nxt[1:0] = tsvd_pkg::LAB_I;
      end else begin
        ne_nxt = e_from_x;
        bp_nxt[1:0] = tsvd_pkg::LAB_X;
      end
    end else if (g_r[0] < e_from_x) begin
      ne_nxt = g_r[0];
    end else begin
      ne_nxt = e_from_x;
      bp_nxt[1:0] = tsvd_pkg::LAB_X;
    end
    if (g_r[1] < i_from_e) begin
      ni_nxt = i_from_i;
      bp_nxt[2] = 1'b1;
    end else begin
      ni_nxt = i_from_e;
    end
    if (x_from_e < g_r[2]) begin
      nx_nxt = x_from_e;
    end else begin
      nx_nxt = x_from_x;
      bp_nxt[3] = 1'b1;
    end
  end

  always_comb begin
    unique case (lab_r)
      tsvd_pkg::LAB_E: lab_nxt = (bp_rdata_r[1:0] == 2'd3) ? tsvd_pkg::LAB_E : bp_rdata_r[1:0];
      tsvd_pkg::LAB_I: lab_nxt = bp_rdata_r[2] ? tsvd_pkg::LAB_I : tsvd_pkg::LAB_E;
      default:         lab_nxt = bp_rdata_r[3] ? tsvd_pkg::LAB_X : tsvd_pkg::LAB_E;
    endcase
    out_label = (is_read_r && !bad_r) ? ps_rdata_r : tsvd_pkg::LAB_E;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ACS) begin
      bp_mem[count_r[AW-1:0]] <= bp_nxt;
    end
    if (state_r == ST_TRACE_RD) begin
      bp_rdata_r <= bp_mem[p_dec[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_TRACE_WR) begin
      ps_mem[p_dec[AW-1:0]] <= lab_r;
    end
    if (in_fire && in_action == tsvd_pkg::ACT_READ) begin
      ps_rdata_r <= ps_mem[idx_x[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_sum * gain_r;
    if (state_r == ST_MUL && step_r != 2'd0) begin
      g_r[step_r - 2'd1] <= tsvd_pkg::gain_round(prod_r);
    end
    if (in_fire) begin
      ce_r <= in_ce;
      ci_r <= in_ci;
      cx_r <= in_cx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      gain_r      <= tsvd_pkg::GainW'(4096);
      se_r        <= '0;
      si_r        <= '0;
      sx_r        <= '0;
      count_r     <= '0;
      p_r         <= '0;
      new_seq_r   <= 1'b1;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      lab_r       <= tsvd_pkg::LAB_E;
      best_r      <= '0;
      is_read_r   <= 1'b0;
      bad_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        gain_r <= cfg_wr_data;
      end
      if (out_valid_r && out_tready && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          step_r <= '0;
          if (in_fire) begin
            unique case (in_action)
              tsvd_pkg::ACT_PUSH: begin
                if (new_seq_r) begin
                  se_r      <= '0;
                  si_r      <= '0;
                  sx_r      <= '0;
                  count_r   <= '0;
                  ovf_r     <= 1'b0;
                  new_seq_r <= 1'b0;
                  state_r   <= ST_MUL;
                end else if (count_r == CW'(MAX_LEN)) begin
                  ovf_r <= 1'b1;
                end else begin
                  state_r <= ST_MUL;
                end
              end
              tsvd_pkg::ACT_FINISH: begin
                if (se_r < sx_r) begin
                  lab_r  <= tsvd_pkg::LAB_E;
                  best_r <= se_r;
                end else begin
                  lab_r  <= tsvd_pkg::LAB_X;
                  best_r <= sx_r;
                end
                new_seq_r <= 1'b1;
                is_read_r <= 1'b0;
                bad_r     <= 1'b0;
                p_r       <= count_r;
                state_r   <= (count_r == '0) ? ST_EMIT : ST_TRACE_RD;
              end
              tsvd_pkg::ACT_READ: begin
                is_read_r <= 1'b1;
                bad_r     <= rd_bad;
                state_r   <= ST_EMIT;
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_MUL: begin
          step_r <= step_r + 2'd1;
          if (step_r == 2'd3) begin
            state_r <= ST_ACS;
          end
        end
        ST_ACS: begin
          se_r    <= ne_nxt;
          si_r    <= ni_nxt;
          sx_r    <= nx_nxt;
          count_r <= count_r + CW'(1);
          state_r <= ST_IDLE;
        end
        ST_TRACE_RD: begin
          state_r <= ST_TRACE_WR;
        end
        ST_TRACE_WR: begin
          lab_r   <= lab_nxt;
          p_r     <= p_dec;
          state_r <= (p_r == CW'(1)) ? ST_EMIT : ST_TRACE_RD;
        end
        ST_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && (!out_valid_r || out_tready)) begin
      out_data_r <= {7'd0, is_read_r && bad_r, ovf_r, cnt_p[tsvd_pkg::LenW-1:0],
                     is_read_r ? tsvd_pkg::score_t'(0) : best_r, out_label};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_LEN))
    else $error("position count exceeds capacity");

  a_acs_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ACS |-> count_r < CW'(MAX_LEN))
    else $error("add-compare-select step with a full back-pointer store");

  a_overflow_set: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_action == tsvd_pkg::ACT_PUSH && !new_seq_r && count_r == CW'(MAX_LEN)
    |=> ovf_r && state_r == ST_IDLE)
    else $error("push at capacity did not raise overflow");

  a_trace_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TRACE_RD || state_r == ST_TRACE_WR) |-> p_r != '0)
    else $error("trace-back running past the first position");

endmodule
`default_nettype wire

// ===== sim/three_state_viterbi_decoder_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the three-state Viterbi decoder, predicting every result item.
module three_state_viterbi_decoder_top_test;

  localparam int PathCap      = 4096;
  localparam int RandomItems  = 1200;
  localparam int SettleCycles = 16;
  localparam int StallLimit   = 40000;

  typedef struct packed {
    logic                      bad;
    logic                      ovf;
    logic [tsvd_pkg::LenW-1:0] len;
    tsvd_pkg::score_t          score;
    tsvd_pkg::label_t          lab;
  } dec_result_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_wr_en;
  logic [tsvd_pkg::GainW-1:0]    cfg_wr_data;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [tsvd_pkg::InDataW-1:0]  in_tdata;
  logic [1:0]                    in_tuser;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [tsvd_pkg::OutDataW-1:0] out_tdata;

  three_state_viterbi_decoder_top #(
    .MAX_LEN(PathCap)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Predictor state.
  logic [tsvd_pkg::GainW-1:0] gain_q412;
  tsvd_pkg::score_t           path_e, path_i, path_x;
  tsvd_pkg::bptr_t            bptr_mem [PathCap];
  tsvd_pkg::label_t           trace_mem [PathCap];
  int                         pos_count;
  bit                         fresh_seq;
  bit                         ovf_flag;
  int                         traced_hi;

  dec_result_t pending_results[$];

  bit idle_on;
  int hold_len;
  int rx_gap;
  int err_cnt;
  int items_sent;
  int results_seen;
  int seq_cnt;
  int gain_writes;
  int stall_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic tsvd_pkg::score_t add_cost_sat(tsvd_pkg::score_t s, tsvd_pkg::cost_t c);
    logic [tsvd_pkg::ScoreW:0] t;
    t = {1'b0, s} + (tsvd_pkg::ScoreW + 1)'(c);
    return t[tsvd_pkg::ScoreW] ? {tsvd_pkg::ScoreW{1'b1}} : t[tsvd_pkg::ScoreW-1:0];
  endfunction

  function automatic tsvd_pkg::score_t add_cost_gained(tsvd_pkg::score_t s,
                                                       tsvd_pkg::cost_t c);
    logic [63:0] t;
    t = ((64'(s) + 64'(c)) * 64'(gain_q412) + 64'd2048) >> tsvd_pkg::GainFrac;
    return (t[63:tsvd_pkg::ScoreW] != '0) ? {tsvd_pkg::ScoreW{1'b1}} :
                                            t[tsvd_pkg::ScoreW-1:0];
  endfunction

  // Applies one accepted item to the predictor and queues the result item it causes.
  function automatic void decode_predict(tsvd_pkg::action_t act, tsvd_pkg::cost_t ce,
                                         tsvd_pkg::cost_t ci, tsvd_pkg::cost_t cx,
                                         logic [tsvd_pkg::IndexW-1:0] idx);
    tsvd_pkg::score_t a, b, c, ne, ni, nx;
    tsvd_pkg::bptr_t  bp;
    tsvd_pkg::label_t lab;
    dec_result_t      r;
    r = '0;
    case (act)
      tsvd_pkg::ACT_PUSH: begin
        if (fresh_seq) begin
          path_e = '0;
          path_i = '0;
          path_x = '0;
          pos_count = 0;
          ovf_flag = 1'b0;
          fresh_seq = 1'b0;
        end
        if (pos_count >= PathCap) begin
          ovf_flag = 1'b1;
        end else begin
          bp = '0;
          a = add_cost_sat(path_i, ce);
          b = add_cost_gained(path_e, ce);
          c = add_cost_sat(path_x, ce);
          if (a < b) begin
            if (a < c) begin
              ne = a;
              bp[1:0] = tsvd_pkg::LAB_I;
            end else begin
              ne = c;
              bp[1:0] = tsvd_pkg::LAB_X;
            end
          end else if (b < c) begin
            ne = b;
          end else begin
            ne = c;
            bp[1:0] = tsvd_pkg::LAB_X;
          end
          if (add_cost_gained(path_i, ci) < add_cost_sat(path_e, ci)) begin
            ni = add_cost_sat(path_i, ci);
            bp[2] = 1'b1;
          end else begin
            ni = add_cost_sat(path_e, ci);
          end
          a = add_cost_sat(path_e, cx);
          if (a < add_cost_gained(path_x, cx)) begin
            nx = a;
          end else begin
            nx = add_cost_sat(path_x, cx);
            bp[3] = 1'b1;
          end
          path_e = ne;
          path_i = ni;
          path_x = nx;
          bptr_mem[pos_count] = bp;
          pos_count++;
        end
      end
      tsvd_pkg::ACT_FINISH: begin
        if (path_e < path_x) begin
          lab = tsvd_pkg::LAB_E;
          r.score = path_e;
        end else begin
          lab = tsvd_pkg::LAB_X;
          r.score = path_x;
        end
        for (int p = pos_count - 1; p >= 0; p--) begin
          bp = bptr_mem[p];
          trace_mem[p] = lab;
          case (lab)
            tsvd_pkg::LAB_E: lab = (bp[1:0] > tsvd_pkg::LAB_X) ? tsvd_pkg::LAB_E : bp[1:0];
            tsvd_pkg::LAB_I: lab = bp[2] ? tsvd_pkg::LAB_I : tsvd_pkg::LAB_E;
            default: lab = bp[3] ? tsvd_pkg::LAB_X : tsvd_pkg::LAB_E;
          endcase
        end
        fresh_seq = 1'b1;
        if (pos_count > traced_hi) traced_hi = pos_count;
        r.lab = tsvd_pkg::LAB_E;
        r.len = tsvd_pkg::LenW'(pos_count);
        r.ovf = ovf_flag;
        pending_results.push_back(r);
      end
      tsvd_pkg::ACT_READ: begin
        r.bad = (int'(idx) >= pos_count);
        r.lab = r.bad ? tsvd_pkg::LAB_E : trace_mem[idx];
        r.len = tsvd_pkg::LenW'(pos_count);
        r.ovf = ovf_flag;
        pending_results.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic tsvd_pkg::cost_t pick_cost();
    case ($urandom_range(0, 3))
      0: return tsvd_pkg::cost_t'($urandom);
      1: return tsvd_pkg::cost_t'($urandom_range(0, 255));
      2: return $urandom_range(0, 1) ? {tsvd_pkg::CostW{1'b1}} : '0;
      default: return tsvd_pkg::cost_t'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic send_item(tsvd_pkg::action_t act, tsvd_pkg::cost_t ce, tsvd_pkg::cost_t ci,
                           tsvd_pkg::cost_t cx, logic [tsvd_pkg::IndexW-1:0] idx);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= tsvd_pkg::InDataW'({idx, cx, ci, ce});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_predict(act, ce, ci, cx, idx);
    if (act != tsvd_pkg::ACT_NOP) items_sent++;
  endtask

  task automatic send_push(tsvd_pkg::cost_t ce, tsvd_pkg::cost_t ci, tsvd_pkg::cost_t cx);
    send_item(tsvd_pkg::ACT_PUSH, ce, ci, cx, tsvd_pkg::IndexW'($urandom));
  endtask

  task automatic send_finish();
    send_item(tsvd_pkg::ACT_FINISH, tsvd_pkg::cost_t'($urandom), tsvd_pkg::cost_t'($urandom),
              tsvd_pkg::cost_t'($urandom), tsvd_pkg::IndexW'($urandom));
  endtask

  // Positions that were counted but never traced back hold no defined label, so such
  // reads are redirected to a traced position or past the end of the path, or else replaced by a no-op.
  task automatic send_read(logic [tsvd_pkg::IndexW-1:0] idx);
    if (int'(idx) < pos_count && int'(idx) >= traced_hi) begin
      if (traced_hi > 0) begin
        idx = tsvd_pkg::IndexW'($urandom_range(0, traced_hi - 1));
      end else if (pos_count < PathCap) begin
        idx = tsvd_pkg::IndexW'(pos_count);
      end else begin
        send_item(tsvd_pkg::ACT_NOP, tsvd_pkg::cost_t'($urandom), tsvd_pkg::cost_t'($urandom),
                  tsvd_pkg::cost_t'($urandom), idx);
        return;
      end
    end
    send_item(tsvd_pkg::ACT_READ, tsvd_pkg::cost_t'($urandom), tsvd_pkg::cost_t'($urandom),
              tsvd_pkg::cost_t'($urandom), idx);
  endtask

  task automatic drain();
    @(negedge clk) in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_gain(logic [tsvd_pkg::GainW-1:0] g);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= g;
    @(negedge clk) cfg_wr_en <= 1'b0;
    gain_q412 = g;
    gain_writes++;
  endtask

  task automatic test_directed();
    send_finish();
    send_read('0);
    send_item(tsvd_pkg::ACT_NOP, '1, '1, '1, '1);
    send_push('0, '0, '0);
    send_push('1, '1, '1);
    send_push(16'h0100, 16'h8000, 16'h0001);
    send_push('1, '0, '1);
    send_finish();
    send_finish();
    send_read(12'd0);
    send_read(12'd1);
    send_read(12'd2);
    send_read(12'd3);
    send_read(12'd4);
    send_read('1);
    send_push(16'h00FF, 16'hFF00, 16'h5A5A);
    send_read(12'd0);
    send_read(12'd2);
    send_finish();
    send_read(12'd0);
    drain();
  endtask

  task automatic test_backpressure();
    int k;
    idle_on = 1'b0;
    for (k = 0; k < 8; k++) send_push(pick_cost(), pick_cost(), pick_cost());
    @(posedge clk);
    hold_len = 300;
    send_finish();
    for (k = 0; k < 6; k++) send_push(pick_cost(), pick_cost(), pick_cost());
    for (k = 0; k < 4; k++) send_read(tsvd_pkg::IndexW'($urandom_range(0, 7)));
    send_finish();
    idle_on = 1'b1;
    drain();
  endtask

  task automatic run_random_sequence();
    int len;
    int k;
    int nreads;
    idle_on = ($urandom_range(0, 3) != 0);
    len = ($urandom_range(0, 11) == 0) ? $urandom_range(40, 250) : $urandom_range(1, 20);
    for (k = 0; k < len; k++) begin
      case ($urandom_range(0, 24))
        0: send_item(tsvd_pkg::ACT_NOP, pick_cost(), pick_cost(), pick_cost(),
                     tsvd_pkg::IndexW'($urandom));
        1: send_read(tsvd_pkg::IndexW'($urandom));
        default: send_push(pick_cost(), pick_cost(), pick_cost());
      endcase
    end
    // Now and then the sequence is left open and the next one keeps extending it.
    if ($urandom_range(0, 7) != 0) begin
      send_finish();
      if ($urandom_range(0, 4) == 0) send_finish();
    end
    nreads = $urandom_range(0, 4);
    for (k = 0; k < nreads; k++) begin
      if ($urandom_range(0, 4) == 0) send_read(tsvd_pkg::IndexW'($urandom));
      else send_read(tsvd_pkg::IndexW'($urandom_range(0, pos_count)));
    end
    seq_cnt++;
  endtask

  task automatic test_random_sequences();
    logic [tsvd_pkg::GainW-1:0] gain_plan [5];
    int                         goal;
    gain_plan[0] = 16'd4096;
    gain_plan[1] = '0;
    gain_plan[2] = '1;
    gain_plan[3] = tsvd_pkg::GainW'($urandom_range(3000, 5200));
    gain_plan[4] = tsvd_pkg::GainW'($urandom);
    foreach (gain_plan[ph]) begin
      drain();
      write_gain(gain_plan[ph]);
      goal = items_sent + RandomItems / 5;
      while (items_sent < goal) run_random_sequence();
    end
    drain();
  endtask

  // Result checker and receiver idling.
  always @(posedge clk) begin : check_results
    dec_result_t got;
    dec_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = dec_result_t'(out_tdata[$bits(dec_result_t)-1:0]);
      results_seen++;
      rx_gap = idle_on ? $urandom_range(0, 6) : 0;
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("%0t: result item with nothing expected: label %0d score %h len %0d",
                   $realtime, got.lab, got.score, got.len);
      end else begin
        want = pending_results.pop_front();
        if (got.lab !== want.lab || got.score !== want.score || got.len !== want.len ||
            got.ovf !== want.ovf || got.bad !== want.bad) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("%0t: mismatch, expected label %0d score %h len %0d ovf %b bad %b,",
                     $realtime, want.lab, want.score, want.len, want.ovf, want.bad);
            $display("  got label %0d score %h len %0d ovf %b bad %b",
                     got.lab, got.score, got.len, got.ovf, got.bad);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_len > 0) begin
      out_tready <= 1'b0;
      hold_len--;
    end else if (rx_gap > 0) begin
      out_tready <= 1'b0;
      rx_gap--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
      if (stall_cnt >= StallLimit) begin
        $display("Timeout: no item moved for %0d cycles.", StallLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = tsvd_pkg::ACT_NOP;
    idle_on     = 1'b1;
    hold_len    = 0;
    rx_gap      = 0;
    gain_q412   = 16'd4096;
    path_e      = '0;
    path_i      = '0;
    path_x      = '0;
    pos_count   = 0;
    fresh_seq   = 1'b1;
    ovf_flag    = 1'b0;
    traced_hi   = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_directed();
    test_backpressure();
    test_random_sequences();
    drain();

    $display("Sent %0d items in %0d random sequences under %0d gain settings.",
             items_sent, seq_cnt, gain_writes);
    $display("Checked %0d result items, including a long output hold-off against a busy sender.",
             results_seen);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures.", err_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
